@@ rtl/core/pcle_pkg.sv @@
// ----------------------------------------------------------------------------
// pcle_pkg
// shared types and codes of the positional circular list engine
// ----------------------------------------------------------------------------
package pcle_pkg;

  localparam int CAPACITY_DEF = 256;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_GET    = 3'd4,
    MODE_SET    = 3'd5,
    MODE_JOS    = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_BAD_POS = 3'd1,
    STAT_EMPTY   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_BAD_JOS = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CHECK,
    CMD_UP_RD,
    CMD_UP_WR,
    CMD_INS_WR,
    CMD_APP_WR,
    CMD_DN_RD,
    CMD_DN_WR,
    CMD_DEC,
    CMD_S_RD,
    CMD_S_CMP,
    CMD_G_RD,
    CMD_CAP,
    CMD_SET_WR,
    CMD_J_APP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DROP_INIT,
    CMD_H_RD,
    CMD_FIN
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UP_RD,
    ST_UP_WR,
    ST_INS_WR,
    ST_APP,
    ST_DN_RD,
    ST_DN_WR,
    ST_S_RD,
    ST_S_CMP,
    ST_G_RD,
    ST_CAP,
    ST_SET,
    ST_J_APP,
    ST_J_LOOP,
    ST_J_DIV,
    ST_J_DROP,
    ST_H_RD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    status_t    err;
    logic       up_done;
    logic       dn_done;
    logic       srch_done;
    logic       match;
    logic       j_last;
    logic       div_last;
    logic       cnt_le1;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ rtl/core/pcle_dp.sv @@
// ----------------------------------------------------------------------------
// pcle_dp
// datapath: entry memory, length, index and remainder unit, result registers
// ----------------------------------------------------------------------------
module pcle_dp #(
  parameter int CAPACITY = pcle_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcle_pkg::cmd_t     cmd,
  output pcle_pkg::dp_stat_t stat,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_item_value,
  input  logic [9:0]         in_slot,
  input  logic [8:0]         in_people,
  input  logic [15:0]        in_stride,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_found_slot,
  output logic               out_found,
  output logic [8:0]         out_list_length
);
  import pcle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > 10) ? CW : 10) + 1;
  localparam int SW = ((CW > 16) ? CW : 16) + 1;
  localparam int BW = $clog2(SW + 1);
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata_r;
  logic [2:0]    mode_r;
  logic [31:0]   val_r;
  logic [9:0]    pos_r;
  logic [8:0]    n_r;
  logic [15:0]   m_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cur_r;
  logic [CW-1:0] rem_r;
  logic [SW-1:0] dvd_r;
  logic [BW-1:0] bc_r;
  status_t       st_r;
  logic [31:0]   rd_r;
  logic          fnd_r;
  logic [8:0]    fslot_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [31:0]   out_rd_r;
  logic [8:0]    out_fslot_r;
  logic          out_fnd_r;
  logic [8:0]    out_len_r;

  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] idx_e;
  status_t       err;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW:0]   div_tmp;
  logic [CW-1:0] div_rem;

  assign pos_e = EW'(pos_r);
  assign cnt_e = EW'(cnt_r);
  assign idx_e = EW'(idx_r);

  always_comb begin
    err = STAT_OK;
    case (mode_r)
      MODE_INSERT: begin
        if (pos_e == '0 || pos_e > cnt_e + EW'(1)) err = STAT_BAD_POS;
        else if (cnt_e >= CAP_E) err = STAT_FULL;
      end
      MODE_APPEND: begin
        if (cnt_e >= CAP_E) err = STAT_FULL;
      end
      MODE_REMOVE, MODE_GET, MODE_SET: begin
        if (cnt_e == '0) err = STAT_EMPTY;
        else if (pos_e == '0 || pos_e > cnt_e) err = STAT_BAD_POS;
      end
      MODE_JOS: begin
        if (n_r == '0 || m_r == '0) err = STAT_BAD_JOS;
        else if (cnt_e + EW'(n_r) > CAP_E) err = STAT_FULL;
      end
      default: err = STAT_OK;
    endcase
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rdata_r;
    case (cmd)
      CMD_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_e - EW'(1));
      end
      CMD_UP_WR, CMD_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r);
      end
      CMD_INS_WR, CMD_SET_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pos_e - EW'(1));
        wr_data = val_r;
      end
      CMD_APP_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = val_r;
      end
      CMD_J_APP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = 32'(idx_r);
      end
      CMD_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_e + EW'(1));
      end
      CMD_S_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx_r);
      end
      CMD_G_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos_e - EW'(1));
      end
      CMD_H_RD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // one remainder bit per step
  assign div_tmp = {rem_r, dvd_r[SW-1]};
  assign div_rem = (div_tmp >= {1'b0, cnt_r}) ? CW'(div_tmp - {1'b0, cnt_r}) : CW'(div_tmp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cmd)
        CMD_INS_WR, CMD_APP_WR, CMD_J_APP: cnt_r <= cnt_r + CW'(1);
        CMD_DEC:                           cnt_r <= cnt_r - CW'(1);
        default:                           cnt_r <= cnt_r;
      endcase
      if (cmd == CMD_FIN) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        mode_r <= in_mode;
        val_r  <= in_item_value;
        pos_r  <= in_slot;
        n_r    <= in_people;
        m_r    <= in_stride;
      end
      CMD_CHECK: begin
        st_r    <= err;
        rd_r    <= '0;
        fnd_r   <= 1'b0;
        fslot_r <= '0;
        cur_r   <= '0;
        case (mode_r)
          MODE_INSERT: idx_r <= cnt_r;
          MODE_REMOVE: idx_r <= CW'(pos_e - EW'(1));
          MODE_JOS:    idx_r <= CW'(1);
          default:     idx_r <= '0;
        endcase
      end
      CMD_UP_WR: idx_r <= idx_r - CW'(1);
      CMD_DN_WR: idx_r <= idx_r + CW'(1);
      CMD_J_APP: idx_r <= idx_r + CW'(1);
      CMD_S_CMP: begin
        if (rdata_r == val_r) begin
          fnd_r   <= 1'b1;
          fslot_r <= 9'(idx_e + EW'(1));
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      CMD_DEC: begin
        if (mode_r == MODE_JOS && cur_r >= cnt_r - CW'(1)) begin
          cur_r <= '0;
        end
      end
      CMD_DIV_INIT: begin
        dvd_r <= SW'(cur_r) + SW'(m_r) - SW'(1);
        rem_r <= '0;
        bc_r  <= BW'(SW);
      end
      CMD_DIV_STEP: begin
        rem_r <= div_rem;
        dvd_r <= {dvd_r[SW-2:0], 1'b0};
        bc_r  <= bc_r - BW'(1);
      end
      CMD_DROP_INIT: begin
        cur_r <= rem_r;
        idx_r <= rem_r;
      end
      CMD_CAP: rd_r <= rdata_r;
      CMD_FIN: begin
        out_status_r <= st_r;
        out_rd_r     <= rd_r;
        out_fslot_r  <= fslot_r;
        out_fnd_r    <= fnd_r;
        out_len_r    <= 9'(cnt_r);
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  always_comb begin
    stat.mode      = mode_r;
    stat.err       = err;
    stat.up_done   = idx_e == pos_e - EW'(1);
    stat.dn_done   = idx_e + EW'(1) >= cnt_e;
    stat.srch_done = idx_r >= cnt_r;
    stat.match     = rdata_r == val_r;
    stat.j_last    = idx_e == EW'(n_r);
    stat.div_last  = bc_r == BW'(1);
    stat.cnt_le1   = cnt_r <= CW'(1);
    stat.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = $signed(out_rd_r);
  assign out_found_slot  = out_fslot_r;
  assign out_found       = out_fnd_r;
  assign out_list_length = out_len_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(cnt_r) <= CAP_E)
    else $error("list length above capacity");

  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> EW'(wr_addr) <= cnt_e)
    else $error("write beyond end of list");

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_FIN |-> !(out_valid_r && out_stall))
    else $error("result overwrites stalled item");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_DIV_STEP |-> rem_r < cnt_r)
    else $error("remainder out of range");

endmodule

@@ rtl/core/pcle_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcle_ctrl
// controller: sequences each operation as datapath commands
// ----------------------------------------------------------------------------
module pcle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcle_pkg::dp_stat_t stat,
  output pcle_pkg::cmd_t     cmd
);
  import pcle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd = CMD_CHECK;
        if (stat.err != STAT_OK) begin
          state_nxt = ST_FIN;
        end else begin
          case (stat.mode)
            MODE_INSERT: state_nxt = ST_UP_RD;
            MODE_APPEND: state_nxt = ST_APP;
            MODE_REMOVE: state_nxt = ST_DN_RD;
            MODE_SEARCH: state_nxt = ST_S_RD;
            MODE_GET:    state_nxt = ST_G_RD;
            MODE_SET:    state_nxt = ST_SET;
            MODE_JOS:    state_nxt = ST_J_APP;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_UP_RD: begin
        if (stat.up_done) begin
          state_nxt = ST_INS_WR;
        end else begin
          cmd       = CMD_UP_RD;
          state_nxt = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        cmd       = CMD_UP_WR;
        state_nxt = ST_UP_RD;
      end
      ST_INS_WR: begin
        cmd       = CMD_INS_WR;
        state_nxt = ST_FIN;
      end
      ST_APP: begin
        cmd       = CMD_APP_WR;
        state_nxt = ST_FIN;
      end
      // shared by remove and josephus elimination
      ST_DN_RD: begin
        if (stat.dn_done) begin
          cmd       = CMD_DEC;
          state_nxt = (stat.mode == MODE_JOS) ? ST_J_LOOP : ST_FIN;
        end else begin
          cmd       = CMD_DN_RD;
          state_nxt = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        cmd       = CMD_DN_WR;
        state_nxt = ST_DN_RD;
      end
      ST_S_RD: begin
        if (stat.srch_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd       = CMD_S_RD;
          state_nxt = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        cmd       = CMD_S_CMP;
        state_nxt = stat.match ? ST_FIN : ST_S_RD;
      end
      ST_G_RD: begin
        cmd       = CMD_G_RD;
        state_nxt = ST_CAP;
      end
      ST_CAP: begin
        cmd       = CMD_CAP;
        state_nxt = ST_FIN;
      end
      ST_SET: begin
        cmd       = CMD_SET_WR;
        state_nxt = ST_FIN;
      end
      ST_J_APP: begin
        cmd = CMD_J_APP;
        if (stat.j_last) state_nxt = ST_J_LOOP;
      end
      ST_J_LOOP: begin
        if (stat.cnt_le1) begin
          state_nxt = ST_H_RD;
        end else begin
          cmd       = CMD_DIV_INIT;
          state_nxt = ST_J_DIV;
        end
      end
      ST_J_DIV: begin
        cmd = CMD_DIV_STEP;
        if (stat.div_last) state_nxt = ST_J_DROP;
      end
      ST_J_DROP: begin
        cmd       = CMD_DROP_INIT;
        state_nxt = ST_DN_RD;
      end
      ST_H_RD: begin
        cmd       = CMD_H_RD;
        state_nxt = ST_CAP;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd       = CMD_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = state_r != ST_IDLE;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_LOAD |=> state_r == ST_CHECK)
    else $error("load not followed by check");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_FIN |=> !in_stall)
    else $error("block not ready after result");

  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_DROP_INIT |-> $past(cmd == CMD_DIV_STEP))
    else $error("drop without finished remainder");

endmodule

@@ rtl/core/positional_circular_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// positional_circular_list_engine_unit
// ordered list of signed 32-bit values with josephus elimination
// ----------------------------------------------------------------------------
// one item in (mode, value, slot, people, stride), one result item out
// (status, read value, found slot, found flag, list length); both channels
// use valid/stall, an item moves when valid is high and stall is low.
// one item is worked on at a time; in_stall is high from acceptance until
// the result is loaded into the output register, and the next item can be
// taken while that result still waits.
// steps per item: append and set write one entry, get reads one; insert
// shifts the entries from the slot on up one by one, then writes; remove
// shifts the entries behind the slot down one by one; search reads and
// compares entries in order until a match or the end; josephus appends n
// entries, then per elimination computes a remainder and shifts entries down.
// the single-port entry memory (one read or one write a cycle) and the
// bit-serial remainder unit set the pace of these steps.
// a stalled result holds in the output register; the engine then waits at
// its final step. reset (rst_n low, synchronous) empties the list.
// ----------------------------------------------------------------------------
module positional_circular_list_engine_unit #(
  parameter int CAPACITY = pcle_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_item_value,
  input  logic [9:0]         in_slot,
  input  logic [8:0]         in_people,
  input  logic [15:0]        in_stride,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_found_slot,
  output logic               out_found,
  output logic [8:0]         out_list_length
);
  import pcle_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  pcle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_item_value   (in_item_value),
    .in_slot         (in_slot),
    .in_people       (in_people),
    .in_stride       (in_stride),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found_slot  (out_found_slot),
    .out_found       (out_found),
    .out_list_length (out_list_length)
  );

endmodule

@@ dv/pcle_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcle_checker
// watches both channels of the list engine, predicts and compares results
// ----------------------------------------------------------------------------
module pcle_checker #(
  parameter int CAPACITY = pcle_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_item_value,
  input  logic [9:0]         in_slot,
  input  logic [8:0]         in_people,
  input  logic [15:0]        in_stride,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic signed [31:0] out_read_value,
  input  logic [8:0]         out_found_slot,
  input  logic               out_found,
  input  logic [8:0]         out_list_length,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count
);
  import pcle_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [8:0]         found_slot;
    logic               found;
    logic [8:0]         list_length;
  } list_result_t;

  logic [31:0]  list_mem [CAPACITY];
  int           list_len;
  list_result_t result_queue [$];

  assign pending = result_queue.size();

  task automatic remove_entry(input int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endtask

  task automatic apply_op(input logic [2:0] mode, input logic [31:0] val,
                          input int pos, input int n, input int m);
    list_result_t r;
    int cur;
    r = '0;
    r.status = STAT_OK;
    case (mode)
      MODE_INSERT: begin
        if (pos < 1 || pos > list_len + 1) r.status = STAT_BAD_POS;
        else if (list_len >= CAPACITY) r.status = STAT_FULL;
        else begin
          for (int i = list_len; i > pos - 1; i--) list_mem[i] = list_mem[i - 1];
          list_mem[pos - 1] = val;
          list_len++;
        end
      end
      MODE_APPEND: begin
        if (list_len >= CAPACITY) r.status = STAT_FULL;
        else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      MODE_REMOVE, MODE_GET, MODE_SET: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else if (pos < 1 || pos > list_len) r.status = STAT_BAD_POS;
        else if (mode == MODE_REMOVE) remove_entry(pos - 1);
        else if (mode == MODE_GET) r.read_value = list_mem[pos - 1];
        else list_mem[pos - 1] = val;
      end
      MODE_SEARCH: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            r.found = 1'b1;
            r.found_slot = 9'(i + 1);
            break;
          end
        end
      end
      MODE_JOS: begin
        if (n == 0 || m == 0) r.status = STAT_BAD_JOS;
        else if (list_len + n > CAPACITY) r.status = STAT_FULL;
        else begin
          cur = 0;
          for (int i = 1; i <= n; i++) begin
            list_mem[list_len] = 32'(i);
            list_len++;
          end
          while (list_len > 1) begin
            cur = (cur + m - 1) % list_len;
            remove_entry(cur);
            if (cur >= list_len) cur = 0;
          end
          r.read_value = list_mem[0];
        end
      end
      default: ;
    endcase
    r.list_length = 9'(list_len);
    result_queue.push_back(r);
  endtask

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst_n) begin
      list_len <= 0;
      fail_count <= 0;
      result_count <= 0;
      result_queue.delete();
    end else begin
      if (in_valid && !in_stall)
        apply_op(in_mode, in_item_value, in_slot, in_people, in_stride);
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (result_queue.size() == 0) begin
          $display("%0t: result item with none expected: status %0d len %0d",
                   $time, out_status, out_list_length);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_queue.pop_front();
          if (exp_r != {out_status, out_read_value, out_found_slot, out_found,
                        out_list_length}) begin
            $display("%0t: mismatch exp st=%0d rd=%0d fs=%0d f=%0d len=%0d",
                     $time, exp_r.status, exp_r.read_value, exp_r.found_slot,
                     exp_r.found, exp_r.list_length);
            $display("%0t:          got st=%0d rd=%0d fs=%0d f=%0d len=%0d",
                     $time, out_status, out_read_value, out_found_slot,
                     out_found, out_list_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_positional_circular_list_engine_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_circular_list_engine_unit
// directed and random list operations with random idling on both channels
// ----------------------------------------------------------------------------
module tb_positional_circular_list_engine_unit;
  import pcle_pkg::*;

  localparam int CAPACITY   = CAPACITY_DEF;
  localparam int N_RANDOM   = 1350;
  localparam longint LIMIT  = 64'd500_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode = '0;
  logic signed [31:0] in_item_value = '0;
  logic [9:0]         in_slot = '0;
  logic [8:0]         in_people = '0;
  logic [15:0]        in_stride = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic [2:0]         out_status;
  logic signed [31:0] out_read_value;
  logic [8:0]         out_found_slot;
  logic               out_found;
  logic [8:0]         out_list_length;
  int                 fail_count, pending, result_count;
  int                 shadow_len;
  int                 jos_runs;
  longint             cycle_count;
  logic [31:0]        recent_vals [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  positional_circular_list_engine_unit #(.CAPACITY(CAPACITY)) i_dut (.*);

  pcle_checker #(.CAPACITY(CAPACITY)) i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= (rst_n ? cycle_count + 1 : 0);
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stall, random per item with bursts of no stall
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      @(negedge clk) out_stall <= (wait_cycles != 0);
      if (wait_cycles != 0) begin
        repeat (wait_cycles) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // length follows the item for predicting legal positions
  task automatic send_item(input logic [2:0] mode, input logic [31:0] val,
                           input logic [9:0] pos, input logic [8:0] n,
                           input logic [15:0] m, input bit gap);
    int wait_cycles;
    wait_cycles = gap ? $urandom_range(0, 19) : 0;
    // valid stays low for at least the cycle after the previous item
    repeat (wait_cycles + 1) @(negedge clk);
    in_mode <= mode;
    in_item_value <= val;
    in_slot <= pos;
    in_people <= n;
    in_stride <= m;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk) in_valid <= 1'b0;
    case (mode)
      MODE_INSERT: if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY)
        shadow_len++;
      MODE_APPEND: if (shadow_len < CAPACITY) shadow_len++;
      MODE_REMOVE: if (pos >= 1 && pos <= shadow_len) shadow_len--;
      MODE_JOS: if (n != 0 && m != 0 && shadow_len + n <= CAPACITY) begin
        shadow_len = 1;
        jos_runs++;
      end
      default: ;
    endcase
    if (recent_vals.size() > 16) void'(recent_vals.pop_front());
    recent_vals.push_back(val);
  endtask

  function automatic logic [9:0] pick_slot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 10'($urandom);
    if (r == 1) return 10'd0;
    if (r == 2) return 10'(shadow_len + 1);
    return 10'($urandom_range(1, shadow_len > 0 ? shadow_len : 1));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return (recent_vals.size() > 0) ?
             recent_vals[$urandom_range(0, recent_vals.size() - 1)] : 32'd0;
      3: return 32'($urandom_range(0, 300));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] mode;
    logic [8:0] n;
    logic [15:0] m;
    bit gap;
    shadow_len = 0;
    jos_runs = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: errors on empty list, extremes, every mode
    send_item(MODE_REMOVE, 0, 1, 0, 0, 1);
    send_item(MODE_GET, 0, 1, 0, 0, 1);
    send_item(MODE_SET, 5, 1, 0, 0, 0);
    send_item(MODE_SEARCH, 5, 0, 0, 0, 0);
    send_item(MODE_INSERT, 1, 2, 0, 0, 0);
    send_item(MODE_INSERT, 32'h8000_0000, 1, 0, 0, 0);
    send_item(MODE_APPEND, 32'h7fff_ffff, 0, 0, 0, 1);
    send_item(MODE_INSERT, 32'hffff_ffff, 2, 9'h1ff, 16'hffff, 0);
    send_item(MODE_SEARCH, 32'h7fff_ffff, 0, 0, 0, 0);
    send_item(MODE_GET, 0, 3, 0, 0, 0);
    send_item(MODE_GET, 0, 10'h3ff, 0, 0, 0);
    send_item(MODE_SET, 32'h1234_5678, 2, 0, 0, 0);
    send_item(MODE_REMOVE, 0, 4, 0, 0, 0);
    send_item(MODE_REMOVE, 0, 1, 0, 0, 0);
    send_item(3'd7, 32'h5555_aaaa, 10'h2aa, 9'h155, 16'haaaa, 0);
    send_item(MODE_JOS, 0, 0, 0, 3, 0);
    send_item(MODE_JOS, 0, 0, 5, 0, 0);
    send_item(MODE_JOS, 0, 0, 9'd256, 2, 0);
    send_item(MODE_JOS, 0, 0, 7, 3, 1);
    send_item(MODE_JOS, 0, 0, 9'd255, 16'hffff, 0);
    // fill to capacity, then overflow
    while (shadow_len < CAPACITY) send_item(MODE_APPEND, $urandom, 0, 0, 0, 0);
    send_item(MODE_APPEND, 1, 0, 0, 0, 0);
    send_item(MODE_INSERT, 1, 1, 0, 0, 0);
    send_item(MODE_JOS, 0, 0, 1, 1, 0);
    send_item(MODE_GET, 0, 10'd256, 0, 0, 0);
    // wait for all results before random traffic
    while (pending != 0) @(negedge clk);

    for (int k = 0; k < N_RANDOM; k++) begin
      gap = ($urandom_range(0, 3) != 0) && ((k / 100) % 3 != 1);
      if (k == N_RANDOM / 2) while (pending != 0) @(negedge clk);
      case ($urandom_range(0, 19))
        0, 1, 2, 3:  mode = MODE_APPEND;
        4, 5, 6:     mode = MODE_INSERT;
        7, 8, 9:     mode = MODE_REMOVE;
        10, 11, 12:  mode = MODE_SEARCH;
        13, 14:      mode = MODE_GET;
        15, 16:      mode = MODE_SET;
        17:          mode = MODE_JOS;
        18:          mode = 3'd7;
        default:     mode = 3'($urandom);
      endcase
      // mostly small josephus runs, a few large
      n = ($urandom_range(0, 15) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12));
      m = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
      send_item(mode, pick_value(), pick_slot(), n, m, gap);
    end

    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("ran %0d results, %0d completed josephus runs, list at capacity once",
             result_count, jos_runs);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pcle_pkg.sv
rtl/core/pcle_dp.sv
rtl/core/pcle_ctrl.sv
rtl/core/positional_circular_list_engine_unit.sv
dv/pcle_checker.sv
dv/tb_positional_circular_list_engine_unit.sv
